FILE: design/fpa_pkg.sv
// Package for the fixed-point ALU: op codes, payload structs and constants.
package fpa_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int DATA_W = 32;
  localparam int DIV_STEPS = 64;

  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_MUL = 4'd2;
  localparam logic [3:0] OP_DIV = 4'd3;
  localparam logic [3:0] OP_GT  = 4'd4;
  localparam logic [3:0] OP_LT  = 4'd5;
  localparam logic [3:0] OP_GE  = 4'd6;
  localparam logic [3:0] OP_LE  = 4'd7;
  localparam logic [3:0] OP_EQ  = 4'd8;
  localparam logic [3:0] OP_NE  = 4'd9;
  localparam logic [3:0] OP_MIN = 4'd10;
  localparam logic [3:0] OP_MAX = 4'd11;
  localparam logic [3:0] OP_INC = 4'd12;
  localparam logic [3:0] OP_DEC = 4'd13;
  localparam logic [3:0] OP_FROM_INT = 4'd14;
  localparam logic [3:0] OP_TO_INT = 4'd15;

  typedef struct packed {
    logic [3:0]         op;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic               compare_true;
    logic               divide_by_zero;
  } out_item_t;

  // Data passed from cell to cell along the divider chain.
  typedef struct packed {
    logic        vld;
    logic [63:0] quo;   // dividend bits shifting out, quotient bits shifting in
    logic [32:0] rem;
    logic [31:0] dvs;   // divisor magnitude
    logic        neg;   // quotient sign
    logic        div;   // item is a divide with a nonzero divisor
    out_item_t   early; // result and flags of ops other than a divide by nonzero
  } cell_t;

endpackage

FILE: design/fpa_front.sv
// Front stage: decodes the op, computes the non-divide ops and the multiply, seeds the divider.
module fpa_front import fpa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  logic     in_vld,
  input  in_item_t in_item,
  output cell_t    cell_o
);

  cell_t cell_r, cell_nxt;
  logic signed [63:0] prod_r;
  logic               mul_r;
  logic               mul_vld_r;
  cell_t              hold_r;

  // Stage 1: register the product and the decoded item.
  always_comb begin
    logic signed [31:0] a, b;
    logic [31:0] amag, bmag;
    logic signed [63:0] ax;
    a = in_item.operand_a;
    b = in_item.operand_b;
    amag = a[31] ? 32'(-a) : 32'(a);
    bmag = b[31] ? 32'(-b) : 32'(b);
    ax = 64'(a);
    cell_nxt = '0;
    cell_nxt.vld = in_vld;
    cell_nxt.dvs = bmag;
    cell_nxt.neg = a[31] ^ b[31];
    cell_nxt.quo = {32'(amag >> (DATA_W - FRAC_BITS)), 32'(amag << FRAC_BITS)};
    cell_nxt.rem = '0;
    cell_nxt.div = (in_item.op == OP_DIV) && (b != 0);
    case (in_item.op)
      OP_ADD: cell_nxt.early.result = a + b;
      OP_SUB: cell_nxt.early.result = a - b;
      OP_DIV: cell_nxt.early.divide_by_zero = (b == 0);
      OP_GT:  cell_nxt.early.compare_true = a > b;
      OP_LT:  cell_nxt.early.compare_true = a < b;
      OP_GE:  cell_nxt.early.compare_true = a >= b;
      OP_LE:  cell_nxt.early.compare_true = a <= b;
      OP_EQ:  cell_nxt.early.compare_true = a == b;
      OP_NE:  cell_nxt.early.compare_true = a != b;
      OP_MIN: cell_nxt.early.result = (a < b) ? a : b;
      OP_MAX: cell_nxt.early.result = (a > b) ? a : b;
      OP_INC: cell_nxt.early.result = a + 32'sd1;
      OP_DEC: cell_nxt.early.result = a - 32'sd1;
      OP_FROM_INT: cell_nxt.early.result = a <<< FRAC_BITS;
      OP_TO_INT: begin
        // Bias negatives so the arithmetic shift truncates toward zero.
        ax = a[31] ? ax + 64'((64'sd1 <<< FRAC_BITS) - 64'sd1) : ax;
        cell_nxt.early.result = 32'(ax >>> FRAC_BITS);
      end
      default: cell_nxt.early.result = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r.vld <= 1'b0;
      mul_vld_r <= 1'b0;
    end else if (en) begin
      hold_r <= cell_nxt;
      mul_vld_r <= in_vld;
      mul_r <= (in_item.op == OP_MUL);
      prod_r <= 64'(in_item.operand_a) * 64'(in_item.operand_b);
    end
  end

  // Stage 2: scale the product toward zero.
  always_comb begin
    logic signed [63:0] p;
    cell_r = hold_r;
    cell_r.vld = mul_vld_r;
    p = prod_r[63] ? prod_r + ((64'sd1 <<< FRAC_BITS) - 64'sd1) : prod_r;
    if (mul_r) cell_r.early.result = 32'(p >>> FRAC_BITS);
  end

  assign cell_o = cell_r;

endmodule

FILE: design/fpa_div_cell.sv
// One restoring-division cell: retires one quotient bit per cycle while en is high.
module fpa_div_cell import fpa_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  cell_t cell_i,
  output cell_t cell_o
);

  cell_t cell_r, cell_nxt;

  always_comb begin
    logic [32:0] trial;
    logic [33:0] diff;
    cell_nxt = cell_i;
    trial = {cell_i.rem[31:0], cell_i.quo[63]};
    diff = {1'b0, trial} - {2'b0, cell_i.dvs};
    if (!diff[33]) begin
      cell_nxt.rem = diff[32:0];
      cell_nxt.quo = {cell_i.quo[62:0], 1'b1};
    end else begin
      cell_nxt.rem = trial;
      cell_nxt.quo = {cell_i.quo[62:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end else if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_o = cell_r;

endmodule

FILE: design/fixed_point_alu.sv
// Top level of the pipelined signed fixed-point ALU.
// Each item passes one front register with the multiply scaling behind it, then
// 64 divider cells at one quotient bit per cycle while the pipeline advances, then the
// output register; every op takes that path.
// Throughput: one item per cycle; the whole pipeline advances when the output
// register is empty or being taken. Synchronous active-low reset clears valids.
module fixed_point_alu import fpa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  cell_t chain [0:DIV_STEPS];
  logic  en;
  logic  out_valid_r;
  out_item_t out_data_r;
  out_item_t out_data_nxt;

  assign en = !out_valid_r || out_ready;
  assign in_ready = en;

  fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(in_valid),
    .in_item(in_data), .cell_o(chain[0])
  );

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
    fpa_div_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .cell_i(chain[i]), .cell_o(chain[i+1])
    );
  end

  always_comb begin
    out_data_nxt = chain[DIV_STEPS].early;
    if (chain[DIV_STEPS].div) begin
      out_data_nxt.result = chain[DIV_STEPS].neg ? 32'(-chain[DIV_STEPS].quo)
                                                 : chain[DIV_STEPS].quo[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= chain[DIV_STEPS].vld;
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule

FILE: design/fpa_checker.sv
// Port-level checker for the fixed-point ALU, bound to the top level.
module fpa_checker import fpa_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.compare_true && out_data.divide_by_zero))
    else $error("compare and divide flags both set");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.divide_by_zero || out_data.compare_true)
      |-> out_data.result == 0)
    else $error("flagged result not zero");

endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
